// ----- rtl/core/cafl_pkg.sv -----
package cafl_pkg;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_COR1, ST_MAG, ST_INIT2, ST_COR2, ST_ACC2,
    ST_BMUL_R, ST_BFIN_R, ST_BMUL_P, ST_BFIN_P, ST_OUT
  } cafl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       cor_step;
    logic       mag;
    logic       init2;
    logic       acc2;
    logic       bmul;
    logic       bfin;
    logic       sel_pitch;
    logic       out_load;
    logic [4:0] cnt;
  } cafl_cmd_t;

  localparam int          DIV_BITS   = 14;
  // One million is 64 * 15625; the 15625 part is done by a reciprocal
  // multiply that is exact for every numerator below 2^41 / 10073.
  localparam logic [27:0] RECIP_DIV  = 28'd140737489;
  localparam int          RECIP_SHIFT = 41;
  localparam logic [34:0] HALF_US    = 35'd500000;
  localparam logic signed [25:0] HALF_TURN_Z = 26'sd11796480;
  localparam logic [15:0] INV_GAIN   = 16'd39797;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [16:0] WEIGHT_RST = 17'd64225;
  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
  localparam logic        REG_WEIGHT = 1'b0;

  // Arctangent table in 1/65536 degree.
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  atan_tab = 22'd2949120;
      5'd1:  atan_tab = 22'd1740967;
      5'd2:  atan_tab = 22'd919879;
      5'd3:  atan_tab = 22'd466945;
      5'd4:  atan_tab = 22'd234379;
      5'd5:  atan_tab = 22'd117304;
      5'd6:  atan_tab = 22'd58666;
      5'd7:  atan_tab = 22'd29335;
      5'd8:  atan_tab = 22'd14668;
      5'd9:  atan_tab = 22'd7334;
      5'd10: atan_tab = 22'd3667;
      5'd11: atan_tab = 22'd1833;
      5'd12: atan_tab = 22'd917;
      5'd13: atan_tab = 22'd458;
      5'd14: atan_tab = 22'd229;
      5'd15: atan_tab = 22'd115;
      5'd16: atan_tab = 22'd57;
      5'd17: atan_tab = 22'd29;
      5'd18: atan_tab = 22'd14;
      5'd19: atan_tab = 22'd7;
      5'd20: atan_tab = 22'd4;
      5'd21: atan_tab = 22'd2;
      5'd22: atan_tab = 22'd1;
      default: atan_tab = 22'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/complementary_attitude_filter.sv -----
// Complementary attitude filter: one IMU word in, one word of fused roll, pitch
// and integrated yaw out. The two vectoring CORDIC passes run on one shared
// rotator, and the rate scaling is done by a reciprocal multiply. A new word
// is taken only once the previous one has left the pipeline into the output
// register. The gyro weight register sits at address 0; it is to be written
// only while the block is idle, which the block itself does not enforce.
module complementary_attitude_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [15:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_roll_out,
  output logic signed [16:0] out_pitch_out,
  output logic signed [31:0] out_yaw_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cafl_pkg::*;

  cafl_cmd_t   cmd;
  logic [16:0] weight_r;
  logic        cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_WEIGHT) ? {15'b0, weight_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RST;
    end else if (cfg_wr && (paddr[2] == REG_WEIGHT)) begin
      weight_r <= pwdata[16:0];
    end
  end

  cafl_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cafl_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .gyro_weight   (weight_r),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_elapsed_us (in_elapsed_us),
    .out_roll_out  (out_roll_out),
    .out_pitch_out (out_pitch_out),
    .out_yaw_out   (out_yaw_out)
  );

  // Once a word is taken the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word was in flight");

  // Roll and pitch stay within a half turn.
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_out <= ANGLE_LIMIT) && (out_roll_out >= -ANGLE_LIMIT))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_out <= ANGLE_LIMIT) && (out_pitch_out >= -ANGLE_LIMIT))
    else $error("pitch out of range");

endmodule

// ----- rtl/core/cafl_ctrl.sv -----
module cafl_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cafl_pkg::cafl_cmd_t cmd
);
  import cafl_pkg::*;

  localparam logic [4:0] LAST_COR = 5'(CORDIC_STEPS - 1);

  cafl_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_COR1;
        cnt_nxt   = '0;
      end
      ST_COR1: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_COR) state_nxt = ST_MAG;
      end
      ST_MAG:    state_nxt = ST_INIT2;
      ST_INIT2: begin
        state_nxt = ST_COR2;
        cnt_nxt   = '0;
      end
      ST_COR2: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_COR) state_nxt = ST_ACC2;
      end
      ST_ACC2:   state_nxt = ST_BMUL_R;
      ST_BMUL_R: state_nxt = ST_BFIN_R;
      ST_BFIN_R: state_nxt = ST_BMUL_P;
      ST_BMUL_P: state_nxt = ST_BFIN_P;
      ST_BFIN_P: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.cnt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_COR1:   cmd.cor_step = 1'b1;
      ST_MAG:    cmd.mag = 1'b1;
      ST_INIT2:  cmd.init2 = 1'b1;
      ST_COR2:   cmd.cor_step = 1'b1;
      ST_ACC2:   cmd.acc2 = 1'b1;
      ST_BMUL_R: cmd.bmul = 1'b1;
      ST_BFIN_R: cmd.bfin = 1'b1;
      ST_BMUL_P: begin
        cmd.bmul      = 1'b1;
        cmd.sel_pitch = 1'b1;
      end
      ST_BFIN_P: begin
        cmd.bfin      = 1'b1;
        cmd.sel_pitch = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/cafl_datapath.sv -----
module cafl_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  cafl_pkg::cafl_cmd_t cmd,
  input  logic [16:0]         gyro_weight,
  input  logic signed [15:0]  in_rate_x,
  input  logic signed [15:0]  in_rate_y,
  input  logic signed [15:0]  in_rate_z,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic [15:0]         in_elapsed_us,
  output logic signed [16:0]  out_roll_out,
  output logic signed [16:0]  out_pitch_out,
  output logic signed [31:0]  out_yaw_out
);
  import cafl_pkg::*;

  // Division lanes: x rate, y rate, z rate.
  logic [34:0]         rem_r [3];
  logic [DIV_BITS-1:0] quo_r [3];
  logic                neg_r [3];
  logic signed [14:0]  inc   [3];

  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic               czero_r;
  logic signed [15:0] ax_r;
  logic [31:0]        mag_r;
  logic signed [17:0] pitch_acc_r, roll_acc_r;
  logic signed [36:0] prod_r;
  logic signed [16:0] roll_r, pitch_r;
  logic [31:0]        yaw_r;

  logic signed [33:0] dx, dy;
  logic signed [25:0] dz;
  logic signed [25:0] z_fin;
  logic signed [17:0] z_out;
  logic signed [33:0] init_x, init_y;
  logic [16:0]        w_eff;
  logic signed [16:0] cur_angle;
  logic signed [15:0] cur_inc;
  logic signed [17:0] cur_acc;
  logic signed [18:0] diff;
  logic signed [37:0] acc_sum;
  logic signed [21:0] blend_q;
  logic signed [16:0] blend_sat;

  // Rounded increment per lane, sign restored.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      inc[l] = neg_r[l] ? -$signed({1'b0, quo_r[l]}) : $signed({1'b0, quo_r[l]});
    end
  end

  // One CORDIC micro-rotation.
  assign dx = cy_r >>> cmd.cnt;
  assign dy = cx_r >>> cmd.cnt;
  assign dz = $signed({4'b0, atan_tab(cmd.cnt)});

  assign z_fin = czero_r ? 26'sd0 : cz_r;
  assign z_out = 18'((z_fin + 26'sd128) >>> 8);

  assign init_x   = $signed({2'b0, mag_r});
  assign init_y   = -($signed({{18{ax_r[15]}}, ax_r}) <<< 14);

  // Blend: acc + w*(pred - acc), one multiply.
  assign w_eff     = (gyro_weight > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight;
  assign cur_angle = cmd.sel_pitch ? pitch_r : roll_r;
  assign cur_inc   = cmd.sel_pitch ? 16'(inc[0]) : 16'(inc[1]);
  assign cur_acc   = cmd.sel_pitch ? pitch_acc_r : roll_acc_r;
  assign diff      = 19'(cur_angle) + 19'(cur_inc) - 19'(cur_acc);
  assign acc_sum   = prod_r + ($signed(38'(cur_acc)) <<< 16) + 38'sd32768;
  assign blend_q   = 22'(acc_sum >>> 16);
  assign blend_sat = (blend_q > 22'(ANGLE_LIMIT)) ? ANGLE_LIMIT :
                     (blend_q < -22'(ANGLE_LIMIT)) ? -ANGLE_LIMIT : 17'(blend_q);

  // Working registers.
  always_ff @(posedge clk) begin
    logic signed [34:0] p;
    logic [34:0]        m;
    logic [31:0]        mw;
    if (cmd.load) begin
      p = 35'(in_rate_x * $signed({1'b0, in_elapsed_us})) <<< 2;
      m = p[34] ? 35'(-p) : 35'(p);
      rem_r[0] <= m + HALF_US;  neg_r[0] <= p[34];  quo_r[0] <= '0;
      p = 35'(in_rate_y * $signed({1'b0, in_elapsed_us})) <<< 2;
      m = p[34] ? 35'(-p) : 35'(p);
      rem_r[1] <= m + HALF_US;  neg_r[1] <= p[34];  quo_r[1] <= '0;
      p = 35'(in_rate_z * $signed({1'b0, in_elapsed_us})) <<< 2;
      m = p[34] ? 35'(-p) : 35'(p);
      rem_r[2] <= m + HALF_US;  neg_r[2] <= p[34];  quo_r[2] <= '0;
      ax_r <= in_accel_x;
      czero_r <= (in_accel_z == 16'sd0) && (in_accel_y == 16'sd0);
      if (in_accel_z < 0) begin
        cx_r <= -($signed(34'(in_accel_z)) <<< 14);
        cy_r <= -($signed(34'(in_accel_y)) <<< 14);
        cz_r <= (in_accel_y >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      end else begin
        cx_r <= $signed(34'(in_accel_z)) <<< 14;
        cy_r <= $signed(34'(in_accel_y)) <<< 14;
        cz_r <= '0;
      end
    end
    // Divide by one million: drop six bits, then multiply by the reciprocal
    // of 15625. The rounded numerator stays below 2^34.
    if (cmd.div_step) begin
      for (int l = 0; l < 3; l++) begin
        quo_r[l] <= DIV_BITS'((56'(rem_r[l][33:6]) * 56'(RECIP_DIV)) >> RECIP_SHIFT);
      end
    end
    if (cmd.cor_step) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + dz;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - dz;
      end
    end
    if (cmd.mag) begin
      mw = cx_r[31:0];
      mag_r <= 32'((48'(mw) * 48'(INV_GAIN)) >> 16);
      pitch_acc_r <= z_out;
    end
    if (cmd.init2) begin
      cx_r    <= init_x;
      cy_r    <= init_y;
      cz_r    <= '0;
      czero_r <= (mag_r == 32'd0) && (ax_r == 16'sd0);
    end
    if (cmd.acc2) roll_acc_r <= z_out;
    if (cmd.bmul) prod_r <= $signed({1'b0, w_eff}) * diff;
  end

  // Filter state and result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else if (cmd.bfin) begin
      if (cmd.sel_pitch) begin
        pitch_r <= blend_sat;
        yaw_r   <= yaw_r + 32'(inc[2]);
      end else begin
        roll_r  <= blend_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_roll_out  <= roll_r;
      out_pitch_out <= pitch_r;
      out_yaw_out   <= yaw_r;
    end
  end

endmodule

// ----- dv/complementary_attitude_filter_test.sv -----
`timescale 1ns / 100ps

module complementary_attitude_filter_test;
  import cafl_pkg::*;

  localparam int          ROTATIONS   = 16;
  localparam int          SETTLE      = 2 * ROTATIONS + 40;
  localparam longint      CYCLE_LIMIT = 1500000;
  localparam logic [2:0]  ADDR_WEIGHT = 3'd0;
  localparam logic [2:0]  ADDR_SPARE  = 3'd4;
  localparam longint      HALF_TURN   = 11796480;
  localparam longint      CLAMP       = 46080;
  localparam longint      UNIT_WEIGHT = 65536;

  typedef struct {
    logic signed [15:0] rate_x, rate_y, rate_z;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic [15:0]        elapsed_us;
  } imu_word_t;

  typedef struct {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    logic signed [31:0] yaw;
  } attitude_t;

  typedef struct {
    int rx, ry, rz, ax, ay, az, dt;
    bit typed;
    int roll, pitch, yaw;
  } bench_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_rate_x, in_rate_y, in_rate_z;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic [15:0] in_elapsed_us;
  logic signed [16:0] out_roll_out, out_pitch_out;
  logic signed [31:0] out_yaw_out;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  complementary_attitude_filter #(.CORDIC_STEPS(ROTATIONS)) dut (.*);

  // Arctangent of 2^-i in 1/65536 degree.
  longint arctan_lut [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  // Filter state as the block should hold it.
  longint      est_roll, est_pitch;
  logic [31:0] est_yaw;
  int unsigned gyro_wt;

  attitude_t attitude_q[$];
  int        mismatches;
  int        words_out;
  longint    cycles;
  bit        calm;
  bit        hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Vectoring rotation: returns the angle, leaves the raw magnitude in mag.
  function automatic longint vector_angle(input longint x0, input longint y0,
                                          output longint mag);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROTATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += arctan_lut[i];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_lut[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // Angle step in 1/256 degree, rounded half away from zero.
  function automatic longint angle_step(input longint rate, input longint dt);
    longint p, m, q;
    p = 4 * rate * dt;
    m = (p < 0) ? -p : p;
    q = (m + 500000) / 1000000;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint mix_angles(input longint pred, input longint acc);
    longint w, r;
    w = (gyro_wt > UNIT_WEIGHT) ? UNIT_WEIGHT : longint'(gyro_wt);
    r = (w * pred + (UNIT_WEIGHT - w) * acc + 32768) >>> 16;
    if (r > CLAMP) r = CLAMP;
    if (r < -CLAMP) r = -CLAMP;
    return r;
  endfunction

  // Advances the filter state by one sample and returns the new attitude.
  function automatic attitude_t fuse_sample(input imu_word_t s);
    longint raw_mag, mag, spare, pitch_acc, roll_acc;
    attitude_t a;
    pitch_acc = (vector_angle(longint'(s.accel_z) * 16384,
                              longint'(s.accel_y) * 16384, raw_mag) + 128) >>> 8;
    mag = (raw_mag * 39797) >>> 16;
    roll_acc = (vector_angle(mag, -longint'(s.accel_x) * 16384, spare) + 128) >>> 8;
    est_roll  = mix_angles(est_roll + angle_step(s.rate_y, s.elapsed_us), roll_acc);
    est_pitch = mix_angles(est_pitch + angle_step(s.rate_x, s.elapsed_us), pitch_acc);
    est_yaw   = est_yaw + 32'(angle_step(s.rate_z, s.elapsed_us));
    a.roll  = 17'(est_roll);
    a.pitch = 17'(est_pitch);
    a.yaw   = est_yaw;
    return a;
  endfunction

  // Plausible attitude most of the time; otherwise every bit at random.
  function automatic imu_word_t random_sample();
    imu_word_t s;
    if ($urandom_range(99) < 15) begin
      s.rate_x = $urandom;  s.rate_y = $urandom;  s.rate_z = $urandom;
      s.accel_x = $urandom; s.accel_y = $urandom; s.accel_z = $urandom;
      s.elapsed_us = $urandom;
    end else begin
      s.rate_x = 16'(int'($urandom_range(8000)) - 4000);
      s.rate_y = 16'(int'($urandom_range(8000)) - 4000);
      s.rate_z = 16'(int'($urandom_range(8000)) - 4000);
      s.accel_x = 16'(int'($urandom_range(24000)) - 12000);
      s.accel_y = 16'(int'($urandom_range(24000)) - 12000);
      s.accel_z = 16'(int'($urandom_range(32000)) - 8000);
      s.elapsed_us = 16'($urandom_range(1300, 700));
    end
    return s;
  endfunction

  // Offers one word and waits for it to be taken; the expectation is queued
  // at the accepting edge.
  task automatic send_word(input imu_word_t s, input bit typed, input attitude_t fixed);
    attitude_t a;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rate_x     <= s.rate_x;
    in_rate_y     <= s.rate_y;
    in_rate_z     <= s.rate_z;
    in_accel_x    <= s.accel_x;
    in_accel_y    <= s.accel_y;
    in_accel_z    <= s.accel_z;
    in_elapsed_us <= s.elapsed_us;
    do @(posedge clk); while (!in_ready);
    a = fuse_sample(s);
    attitude_q.push_back(typed ? fixed : a);
  endtask

  // Lets the block drain, then writes one register over the APB port.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_WEIGHT) gyro_wt = value & 32'h1FFFF;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_out >= 400) begin
        hold = 700;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    attitude_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (attitude_q.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = attitude_q.pop_front();
        if (out_roll_out !== want.roll) begin
          $error("roll_out: expected %0d, got %0d", want.roll, out_roll_out);
          mismatches++;
        end
        if (out_pitch_out !== want.pitch) begin
          $error("pitch_out: expected %0d, got %0d", want.pitch, out_pitch_out);
          mismatches++;
        end
        if (out_yaw_out !== want.yaw) begin
          $error("yaw_out: expected %0d, got %0d", want.yaw, out_yaw_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("[complementary_attitude_filter] ERROR");
      $finish;
    end
  end

  initial begin
    bench_row_t rows[$];
    imu_word_t s;
    attitude_t fixed;
    int unsigned settings[$];
    in_valid = 1'b0;
    in_rate_x = '0; in_rate_y = '0; in_rate_z = '0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_elapsed_us = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles = 0; mismatches = 0; words_out = 0; calm = 1'b0; hold_done = 1'b0;
    gyro_wt = 64225; est_roll = 0; est_pitch = 0; est_yaw = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: field extremes, the zero vector and the half-turn cases.
    rows = '{
      '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{32767, 32767, 32767, 0, 0, 16384, 65535, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 0, 0, 16384, 65535, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, -16384, 1000, 0, 0, 0, 0},
      '{0, 0, 0, 0, -1, -16384, 1000, 0, 0, 0, 0},
      '{0, 0, 0, 0, 1, -16384, 1000, 0, 0, 0, 0},
      '{100, -100, 50, 32767, 0, 0, 1000, 0, 0, 0, 0},
      '{100, -100, 50, -32768, 0, 0, 1000, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32767, 0, 1000, 0, 0, 0, 0},
      '{0, 0, 0, 0, -32768, 0, 1000, 0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, -32768, 65535, 0, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767, 65535, 0, 0, 0, 0},
      '{32767, -32768, 32767, 1, 1, 1, 0, 0, 0, 0, 0},
      '{1, -1, 1, -1, -1, -1, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 0},
      '{-1, 1, -1, 5000, -5000, -16384, 40000, 0, 0, 0, 0}
    };
    foreach (rows[i]) begin
      s = '{16'(rows[i].rx), 16'(rows[i].ry), 16'(rows[i].rz), 16'(rows[i].ax),
            16'(rows[i].ay), 16'(rows[i].az), 16'(rows[i].dt)};
      fixed = '{17'(rows[i].roll), 17'(rows[i].pitch), 32'(rows[i].yaw)};
      send_word(s, rows[i].typed, fixed);
    end

    // Random phases over several weights, the extremes and an over-range one.
    settings = '{32'd64225, 32'd0, 32'd65536, 32'd131071, $urandom_range(65536),
                 $urandom_range(131071, 65537), 32'd32768};
    foreach (settings[p]) begin
      write_reg(ADDR_WEIGHT, settings[p]);
      if (p == 2) write_reg(ADDR_SPARE, $urandom);
      calm = (p == 4);
      for (int n = 0; n < 185; n++) send_word(random_sample(), 1'b0, fixed);
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[complementary_attitude_filter] OK");
    end else begin
      $display("[complementary_attitude_filter] ERROR");
    end
    $finish;
  end

endmodule
